FILE: hw/rtl/swes_pkg.sv
package swes_pkg;

  localparam int SW     = 32;            // sample width
  localparam int ABS_W  = SW - 1;        // saturated absolute value width
  localparam int CW     = 9;             // count and window length width
  localparam int SUM_W  = ABS_W + CW;    // window sum width
  localparam int RATE_W = 17;            // solve rate, Q0.16 plus the full-scale bit
  localparam int RATE_SHIFT = 16;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  // packed ring word: ok, velocity, abs heading, abs cross-track
  localparam int CROSS_LSB = 0;
  localparam int HEAD_LSB  = ABS_W;
  localparam int VEL_LSB   = 2 * ABS_W;
  localparam int OK_BIT    = 2 * ABS_W + SW;
  localparam int WORD_W    = 2 * ABS_W + SW + 1;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  localparam logic signed [SW-1:0] VEL_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0]        TICK_MAX = {SW{1'b1}};

  typedef struct packed {
    logic                 req_type;
    logic signed [SW-1:0] xtrack_err;
    logic signed [SW-1:0] hdg_err;
    logic signed [SW-1:0] reference_velocity;
    logic                 solve_ok;
  } req_t;

  typedef struct packed {
    logic [CW-1:0]        win_count;
    logic [ABS_W-1:0]     mean_abs_xtrack;
    logic [ABS_W-1:0]     mean_abs_heading;
    logic signed [SW-1:0] min_velocity;
    logic [RATE_W-1:0]    solve_rate;
    logic [SW-1:0]        total_ticks;
    logic                 window_empty;
  } rsp_t;

  typedef struct packed {
    logic [CW-1:0] window_length;
  } cfg_t;

endpackage

FILE: hw/rtl/swes_stream_if.sv
interface swes_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/swes_ram.sv
module swes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/sliding_window_error_stats.sv
// channel  dir  payload                                  accepted when
// req      in   swes_pkg::req_t (record or clear item)   req.valid && req.ready
// rsp      out  swes_pkg::rsp_t (one per item)            rsp.valid && rsp.ready
// cfg      in   swes_pkg::cfg_t (window_length)           cfg.valid && cfg.ready
//
// each item runs a pipelined scan of the ring through the single RAM read port,
// then three bit-serial divisions on one shared divider, one quotient bit per cycle;
// when the window is empty after the item, the divisions are skipped.
// req.ready is high only while idle; the result register frees the input side,
// and a new item may start while the last result still waits on rsp.ready.
// cfg is always ready. synchronous reset: window_length = min(256, WINDOW_DEPTH),
// window empty, tick count zero; the ring itself is not cleared.
module sliding_window_error_stats #(
  parameter int WINDOW_DEPTH = 256
) (
  input logic         clk,
  input logic         rst,
  swes_stream_if.sink   req,
  swes_stream_if.source rsp,
  swes_stream_if.sink   cfg
);

  localparam int AW      = $clog2(WINDOW_DEPTH);
  localparam int DEPTH_W = $clog2(WINDOW_DEPTH + 1);
  localparam int LW      = (DEPTH_W > swes_pkg::CW) ? DEPTH_W : swes_pkg::CW;
  localparam int CW      = swes_pkg::CW;
  localparam int SUM_W   = swes_pkg::SUM_W;
  localparam int ABS_W   = swes_pkg::ABS_W;
  localparam int SW      = swes_pkg::SW;
  localparam int DIV_CNT_W_L = swes_pkg::DIV_CNT_W;
  localparam int WL_RESET_I = (WINDOW_DEPTH < 256) ? WINDOW_DEPTH : 256;
  localparam logic [CW-1:0] WL_RESET = CW'(WL_RESET_I);
  localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  localparam logic [1:0] SEL_CROSS = 2'd0;
  localparam logic [1:0] SEL_HEAD  = 2'd1;
  localparam logic [1:0] SEL_RATE  = 2'd2;

  function automatic logic [ABS_W-1:0] sat_abs(input logic signed [SW-1:0] x);
    logic [SW-1:0] neg;
    begin
      neg = SW'(-x);
      if (x == {1'b1, {(SW-1){1'b0}}}) begin
        sat_abs = {ABS_W{1'b1}};
      end else if (x[SW-1]) begin
        sat_abs = neg[ABS_W-1:0];
      end else begin
        sat_abs = x[ABS_W-1:0];
      end
    end
  endfunction

  logic [1:0]            state;
  logic [CW-1:0]         window_length;
  logic [CW-1:0]         stored_count;
  logic [SW-1:0]         tick_total;
  logic [AW-1:0]         wp;
  logic [AW-1:0]         rp;
  logic [CW-1:0]         scan_k;
  logic                  rd_valid;
  logic [SUM_W-1:0]      sum_c;
  logic [SUM_W-1:0]      sum_h;
  logic signed [SW-1:0]  vmin;
  logic [CW-1:0]         ok_cnt;
  logic [1:0]            div_sel;
  logic [DIV_CNT_W_L-1:0] div_cnt;
  logic [SUM_W-1:0]      quo;
  logic [CW-1:0]         rem;
  logic [ABS_W-1:0]      q_cross;
  logic [ABS_W-1:0]      q_head;
  logic [swes_pkg::RATE_W-1:0] q_rate;

  // ring access
  logic                         ram_we;
  logic [swes_pkg::WORD_W-1:0]  ram_wdata;
  logic [swes_pkg::WORD_W-1:0]  ram_rdata;
  logic [ABS_W-1:0]             rd_cross;
  logic [ABS_W-1:0]             rd_head;
  logic signed [SW-1:0]         rd_vel;
  logic                         rd_ok;

  logic          accept;
  logic          is_record;
  logic [CW-1:0] count_next;
  logic [AW-1:0] wp_next;
  logic          issue;

  logic [CW:0]   shifted;
  logic [CW:0]   divisor;
  logic          ge;
  logic [CW:0]   diff;
  logic [CW-1:0] rem_step;
  logic [SUM_W-1:0] quo_step;

  logic [LW-1:0] cfg_ext;
  logic [LW-1:0] cfg_clamped;
  logic [CW-1:0] wl_next;
  logic          load_out;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign accept     = req.valid && req.ready;
  assign is_record  = (req.data.req_type == swes_pkg::REQ_RECORD);
  assign count_next = is_record ? ((stored_count < window_length) ? stored_count + 1'b1
                                                                   : stored_count)
                                : '0;
  assign wp_next    = is_record ? ((wp == PTR_LAST) ? '0 : wp + 1'b1) : wp;

  assign ram_we    = accept && is_record;
  assign ram_wdata = {req.data.solve_ok, req.data.reference_velocity,
                      sat_abs(req.data.hdg_err), sat_abs(req.data.xtrack_err)};

  swes_ram #(
    .WIDTH (swes_pkg::WORD_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (ram_wdata),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  assign rd_cross = ram_rdata[swes_pkg::CROSS_LSB +: ABS_W];
  assign rd_head  = ram_rdata[swes_pkg::HEAD_LSB +: ABS_W];
  assign rd_vel   = ram_rdata[swes_pkg::VEL_LSB +: SW];
  assign rd_ok    = ram_rdata[swes_pkg::OK_BIT];

  assign issue = (state == S_SCAN) && (scan_k < stored_count);

  // restoring divide step, divisor is the sample count
  assign divisor  = {1'b0, stored_count};
  assign shifted  = {rem, quo[SUM_W-1]};
  assign ge       = (shifted >= divisor);
  assign diff     = shifted - divisor;
  assign rem_step = ge ? diff[CW-1:0] : shifted[CW-1:0];
  assign quo_step = {quo[SUM_W-2:0], ge};

  assign cfg_ext     = LW'(cfg.data.window_length);
  assign cfg_clamped = (cfg_ext == '0) ? LW'(1)
                     : (cfg_ext > LW'(WINDOW_DEPTH)) ? LW'(WINDOW_DEPTH) : cfg_ext;
  assign wl_next     = cfg_clamped[CW-1:0];

  assign load_out = (state == S_LOAD) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= WL_RESET;
      stored_count  <= '0;
      tick_total    <= '0;
      wp            <= '0;
      rd_valid      <= 1'b0;
      rsp.valid     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            stored_count <= count_next;
            wp           <= wp_next;
            rp           <= (wp_next == '0) ? PTR_LAST : wp_next - 1'b1;
            if (!is_record) begin
              tick_total <= '0;
            end else if (tick_total != swes_pkg::TICK_MAX) begin
              tick_total <= tick_total + 1'b1;
            end
            scan_k <= '0;
            sum_c  <= '0;
            sum_h  <= '0;
            vmin   <= swes_pkg::VEL_MAX;
            ok_cnt <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_valid <= issue;
          if (issue) begin
            rp     <= (rp == '0) ? PTR_LAST : rp - 1'b1;
            scan_k <= scan_k + 1'b1;
          end
          if (rd_valid) begin
            sum_c  <= sum_c + SUM_W'(rd_cross);
            sum_h  <= sum_h + SUM_W'(rd_head);
            ok_cnt <= ok_cnt + CW'(rd_ok);
            if (rd_vel < vmin) begin
              vmin <= rd_vel;
            end
          end
          if (!issue && !rd_valid) begin
            if (stored_count == '0) begin
              state <= S_LOAD;
            end else begin
              quo     <= sum_c;
              rem     <= '0;
              div_cnt <= '0;
              div_sel <= SEL_CROSS;
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quo     <= quo_step;
          rem     <= rem_step;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W_L'(SUM_W - 1)) begin
            rem     <= '0;
            div_cnt <= '0;
            case (div_sel)
              SEL_CROSS: begin
                q_cross <= quo_step[ABS_W-1:0];
                quo     <= sum_h;
                div_sel <= SEL_HEAD;
              end
              SEL_HEAD: begin
                q_head  <= quo_step[ABS_W-1:0];
                quo     <= SUM_W'({ok_cnt, {swes_pkg::RATE_SHIFT{1'b0}}});
                div_sel <= SEL_RATE;
              end
              default: begin
                q_rate <= quo_step[swes_pkg::RATE_W-1:0];
                state  <= S_LOAD;
              end
            endcase
          end
        end
        S_LOAD: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      if (cfg.valid && cfg.ready) begin
        window_length <= wl_next;
        if (stored_count > wl_next) begin
          stored_count <= wl_next;
        end
      end
    end
  end

  // result register, loaded once per item
  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.data.win_count    <= stored_count;
      rsp.data.min_velocity <= vmin;
      rsp.data.total_ticks  <= tick_total;
      if (stored_count == '0) begin
        rsp.data.mean_abs_xtrack  <= '0;
        rsp.data.mean_abs_heading <= '0;
        rsp.data.solve_rate       <= '0;
        rsp.data.window_empty     <= 1'b1;
      end else begin
        rsp.data.mean_abs_xtrack  <= q_cross;
        rsp.data.mean_abs_heading <= q_head;
        rsp.data.solve_rate       <= q_rate;
        rsp.data.window_empty     <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    stored_count <= window_length)
    else $error("stored count exceeds window length");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && !is_record |=> stored_count == '0 && tick_total == '0)
    else $error("clear item did not empty the window");

  a_record_ticks: assert property (@(posedge clk) disable iff (rst)
    accept && is_record |=> tick_total != '0)
    else $error("record item did not count a tick");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> {1'b0, rem} < divisor)
    else $error("divider remainder out of range");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_k <= stored_count)
    else $error("scan ran past the window");
`endif

endmodule

FILE: tb/sv/swes_checker.sv
`timescale 1ns / 1ps

module swes_checker (
  input  logic   clk,
  input  logic   rst,
  swes_stream_if req,
  swes_stream_if rsp,
  swes_stream_if cfg,
  output int     fail_count,
  output int     pending
);

  localparam int SW         = swes_pkg::SW;
  localparam int ABS_W      = swes_pkg::ABS_W;
  localparam int SUM_W      = swes_pkg::SUM_W;
  localparam int CW         = swes_pkg::CW;
  localparam int RATE_W     = swes_pkg::RATE_W;
  localparam int DEPTH      = 256;
  localparam int REPORT_MAX = 10;

  logic [ABS_W-1:0]         cross_ring    [DEPTH];
  logic [ABS_W-1:0]         heading_ring  [DEPTH];
  logic signed [SW-1:0]     velocity_ring [DEPTH];
  logic                     ok_ring       [DEPTH];
  logic [$clog2(DEPTH)-1:0] wr_slot;
  int                       held;
  int                       span;
  logic [SW-1:0]            ticks;
  swes_pkg::rsp_t           stats_due [$];
  int                       failures;

  function automatic logic [ABS_W-1:0] sat_magnitude(input logic signed [SW-1:0] x);
    if (x == {1'b1, {(SW-1){1'b0}}}) return {ABS_W{1'b1}};
    return (x < 0) ? ABS_W'(-x) : ABS_W'(x);
  endfunction

  // summary over the newest held entries, oldest slot last
  function automatic swes_pkg::rsp_t window_stats();
    logic [SUM_W-1:0]     cross_sum;
    logic [SUM_W-1:0]     heading_sum;
    logic signed [SW-1:0] vmin;
    int                   ok_total;
    int                   slot;
    swes_pkg::rsp_t       r;
    cross_sum   = '0;
    heading_sum = '0;
    vmin        = swes_pkg::VEL_MAX;
    ok_total    = 0;
    for (int k = 0; k < held; k++) begin
      slot = (int'(wr_slot) + DEPTH - 1 - k) % DEPTH;
      cross_sum   += SUM_W'(cross_ring[slot]);
      heading_sum += SUM_W'(heading_ring[slot]);
      if (velocity_ring[slot] < vmin) vmin = velocity_ring[slot];
      ok_total += int'(ok_ring[slot]);
    end
    r.win_count    = CW'(held);
    r.total_ticks  = ticks;
    r.window_empty = (held == 0);
    if (held == 0) begin
      r.mean_abs_xtrack  = '0;
      r.mean_abs_heading = '0;
      r.min_velocity     = swes_pkg::VEL_MAX;
      r.solve_rate       = '0;
    end else begin
      r.mean_abs_xtrack  = ABS_W'(cross_sum / SUM_W'(held));
      r.mean_abs_heading = ABS_W'(heading_sum / SUM_W'(held));
      r.min_velocity     = vmin;
      r.solve_rate       = RATE_W'((ok_total << swes_pkg::RATE_SHIFT) / held);
    end
    return r;
  endfunction

  always @(posedge clk) begin : track
    swes_pkg::rsp_t want;
    swes_pkg::rsp_t got;
    if (rst) begin
      wr_slot  = '0;
      held     = 0;
      span     = DEPTH;
      ticks    = '0;
      failures = 0;
      stats_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.data.window_length == '0) span = 1;
        else if (cfg.data.window_length > DEPTH) span = DEPTH;
        else span = int'(cfg.data.window_length);
        if (held > span) held = span;
      end

      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        if (stats_due.size() == 0) begin
          if (failures < REPORT_MAX)
            $display("%0t: result beat with no item outstanding: cnt=%0d ticks=%0d",
                     $realtime, got.win_count, got.total_ticks);
          failures++;
        end else begin
          want = stats_due[0];
          stats_due.delete(0);
          if (got.win_count !== want.win_count ||
              got.mean_abs_xtrack !== want.mean_abs_xtrack ||
              got.mean_abs_heading !== want.mean_abs_heading ||
              got.min_velocity !== want.min_velocity ||
              got.solve_rate !== want.solve_rate ||
              got.total_ticks !== want.total_ticks ||
              got.window_empty !== want.window_empty) begin
            if (failures < REPORT_MAX)
              $display({"%0t: stats mismatch\n  exp cnt=%0d ct=%h hd=%h vmin=%h rate=%h",
                        " ticks=%0d empty=%b\n  got cnt=%0d ct=%h hd=%h vmin=%h rate=%h",
                        " ticks=%0d empty=%b"}, $realtime,
                       want.win_count, want.mean_abs_xtrack, want.mean_abs_heading,
                       want.min_velocity, want.solve_rate, want.total_ticks,
                       want.window_empty,
                       got.win_count, got.mean_abs_xtrack, got.mean_abs_heading,
                       got.min_velocity, got.solve_rate, got.total_ticks,
                       got.window_empty);
            failures++;
          end
        end
      end

      if (req.valid && req.ready) begin
        if (req.data.req_type == swes_pkg::REQ_CLEAR) begin
          held  = 0;
          ticks = '0;
        end else begin
          cross_ring[wr_slot]    = sat_magnitude(req.data.xtrack_err);
          heading_ring[wr_slot]  = sat_magnitude(req.data.hdg_err);
          velocity_ring[wr_slot] = req.data.reference_velocity;
          ok_ring[wr_slot]       = req.data.solve_ok;
          wr_slot = wr_slot + 1'b1;
          if (held < span) held++;
          if (ticks != swes_pkg::TICK_MAX) ticks++;
        end
        stats_due.insert(stats_due.size(), window_stats());
      end
    end
    fail_count <= failures;
    pending    <= stats_due.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int SW           = swes_pkg::SW;
  localparam int CW           = swes_pkg::CW;
  localparam int QUIET_LO     = 1000;
  localparam int QUIET_HI     = 1300;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 400;
  localparam int TIMEOUT_NS   = 20_000_000;

  localparam logic signed [SW-1:0] MOST_NEG = {1'b1, {(SW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   sent;

  swes_stream_if #(.T(swes_pkg::req_t)) req_bus ();
  swes_stream_if #(.T(swes_pkg::rsp_t)) rsp_bus ();
  swes_stream_if #(.T(swes_pkg::cfg_t)) cfg_bus ();

  sliding_window_error_stats u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  swes_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_bus),
    .rsp        (rsp_bus),
    .cfg        (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  function automatic logic signed [SW-1:0] rand_word();
    case ($urandom_range(9))
      0: return swes_pkg::VEL_MAX;
      1: return MOST_NEG;
      2: return '0;
      3: return '1;
      4, 5: return SW'(int'($urandom_range(4095)) - 2048);
      default: return $urandom();
    endcase
  endfunction

  function automatic swes_pkg::req_t sample_item(input logic signed [SW-1:0] ct, hd, vel,
                                                 input logic ok);
    swes_pkg::req_t it;
    it.req_type           = swes_pkg::REQ_RECORD;
    it.xtrack_err         = ct;
    it.hdg_err            = hd;
    it.reference_velocity = vel;
    it.solve_ok           = ok;
    return it;
  endfunction

  // clear items carry random sample fields, which the block must ignore
  function automatic swes_pkg::req_t random_item(input bit clear);
    swes_pkg::req_t it;
    it = sample_item(rand_word(), rand_word(), rand_word(), 1'($urandom_range(1)));
    if (clear) it.req_type = swes_pkg::REQ_CLEAR;
    return it;
  endfunction

  task automatic send(input swes_pkg::req_t item);
    while (!(sent >= QUIET_LO && sent < QUIET_HI) && $urandom_range(99) < 10) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.data  <= item;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(input int value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= '{window_length: CW'(value)};
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_phase(input int window, input int count, input int clear_permil);
    wait_idle();
    write_window(window);
    repeat (count) send(random_item($urandom_range(999) < clear_permil));
  endtask

  // response side: random stalls, one long hold-off, one stretch with none
  initial begin : rsp_side
    int taken;
    int hold_left;
    bit held_once;
    taken     = 0;
    hold_left = 0;
    held_once = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready) taken++;
      if (!held_once && taken == HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (taken >= QUIET_LO && taken < QUIET_HI) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= 10);
      end
    end
  end

  initial begin : timeout
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int waited;
    sent = 0;
    rst           <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.data  <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: clear on empty window, field extremes, saturating magnitudes
    send(random_item(1'b1));
    send(sample_item(MOST_NEG, swes_pkg::VEL_MAX, MOST_NEG, 1'b1));
    send(sample_item(swes_pkg::VEL_MAX, MOST_NEG, swes_pkg::VEL_MAX, 1'b0));
    send(sample_item('0, '0, '0, 1'b1));
    send(sample_item('1, SW'(1), '1, 1'b0));
    send(random_item(1'b1));
    send(sample_item(MOST_NEG, MOST_NEG, swes_pkg::VEL_MAX, 1'b1));
    repeat (4) send(random_item(1'b0));
    // shorten below the held count, then zero length, then past the depth
    wait_idle();
    write_window(2);
    repeat (2) send(random_item(1'b0));
    wait_idle();
    write_window(0);
    repeat (2) send(random_item(1'b0));
    wait_idle();
    write_window(300);
    repeat (3) send(random_item(1'b0));

    run_phase(3, 250, 20);
    run_phase(256, 350, 1);
    run_phase(1, 150, 20);
    run_phase(40, 380, 10);
    run_phase(0, 100, 20);
    run_phase(511, 250, 2);
    repeat (3) run_phase($urandom_range(511), 100, 10);

    req_bus.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
